[sv/bth_pkg.sv]
// ----------------------------------------------------------------------------
// bth_pkg: shared types for the blob track history table
// entry record and the token that travels along the cell chain
// ----------------------------------------------------------------------------
package bth_pkg;

    localparam logic ACT_KEYPOINT = 1'b0;
    localparam logic ACT_EOF      = 1'b1;
    localparam logic [15:0] HITS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] size;
        logic [15:0] hits;
        logic [31:0] seen;
    } entry_t;

    // token handed from cell to cell, one hop per cycle
    typedef struct packed {
        logic        vld;
        logic        act;
        logic        done;    // keypoint already matched or appended
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] size;
        logic [31:0] t;
        logic        best_vld;
        entry_t      best;
    } tok_t;

endpackage

[sv/blob_track_history_table_top.sv]
// ----------------------------------------------------------------------------
// blob_track_history_table_top: tracked blob table with favourite report
// row of entry cells walked by one token per transaction
// ----------------------------------------------------------------------------
// A transaction enters on start while busy is low and walks the chain of
// TABLE_DEPTH entry cells, one cell per cycle; busy stays high until the
// result is taken at the end of the chain. A keypoint updates the first
// matching entry or fills the first free one; the table clears at reset.
// An end-of-frame transaction gives one result, held on the fav ports for
// the single cycle that done is high; the receiver cannot stall it, so it
// must take it then.
module blob_track_history_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [15:0] kp_x,
    input  logic [15:0] kp_y,
    input  logic [15:0] kp_size,
    input  logic [31:0] frame_time,
    output logic        done,
    output logic        fav_valid,
    output logic [15:0] fav_x,
    output logic [15:0] fav_y,
    output logic [15:0] fav_size,
    output logic [15:0] fav_count,
    output logic [31:0] fav_last_seen,
    output logic        dropped_flag
);
    import bth_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 2);

    logic [31:0]   r_sq_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          drop_reg;
    logic          done_reg;
    entry_t        fav_reg;
    logic          fav_vld_reg;
    tok_t          head_tok;
    tok_t          chain [TABLE_DEPTH+1];
    tok_t          tail;

    // radius squared taken straight from the write data, ready at the next edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_sq_reg <= 32'd102400;
        else if (cfg_we)
            r_sq_reg <= 32'(cfg_wdata) * 32'(cfg_wdata);
    end

    // token injected at the head of the chain
    always_comb
    begin
        head_tok          = '0;
        head_tok.vld      = start && !busy_reg;
        head_tok.act      = action;
        head_tok.x        = kp_x;
        head_tok.y        = kp_y;
        head_tok.size     = kp_size;
        head_tok.t        = frame_time;
    end

    assign chain[0] = head_tok;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        bth_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .r_sq   (r_sq_reg),
            .tok_in (chain[g]),
            .tok_out(chain[g+1])
        );
    end

    assign tail = chain[TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            drop_reg    <= 1'b0;
            done_reg    <= 1'b0;
            fav_vld_reg <= 1'b0;
            fav_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                // busy drops at the edge that takes the result
                if (cnt_reg == CW'(TABLE_DEPTH))
                    busy_reg <= 1'b0;
            end
            if (tail.vld)
            begin
                if (tail.act == ACT_KEYPOINT && !tail.done)
                    drop_reg <= 1'b1;
                if (tail.act == ACT_EOF)
                begin
                    done_reg    <= 1'b1;
                    fav_vld_reg <= tail.best_vld;
                    fav_reg     <= tail.best_vld ? tail.best : '0;
                end
            end
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign fav_valid     = fav_vld_reg;
    assign fav_x         = fav_reg.x;
    assign fav_y         = fav_reg.y;
    assign fav_size      = fav_reg.size;
    assign fav_count     = fav_reg.hits;
    assign fav_last_seen = fav_reg.seen;
    assign dropped_flag  = drop_reg;

`ifndef SYNTHESIS
    a_tail_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.vld |-> busy_reg) else $error("token left chain while idle");
    a_done_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(tail.vld)) else $error("result without token");
    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(drop_reg) |-> drop_reg) else $error("drop flag cleared");
    a_fav_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fav_vld_reg) |-> fav_reg.hits != 16'd0)
        else $error("favourite with zero hits");
`endif

endmodule

[sv/bth_cell.sv]
// ----------------------------------------------------------------------------
// bth_cell: one table entry
// matches, appends or competes for the favourite as the token passes
// ----------------------------------------------------------------------------
module bth_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   r_sq,
    input  bth_pkg::tok_t tok_in,
    output bth_pkg::tok_t tok_out
);
    import bth_pkg::*;

    logic        used_reg;
    logic        used_next;
    entry_t      ent_reg;
    entry_t      ent_next;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [31:0] dx_sq;
    logic [31:0] dy_sq;
    logic [32:0] d_sq;
    logic        near;

    assign dx    = (tok_in.x >= ent_reg.x) ? tok_in.x - ent_reg.x : ent_reg.x - tok_in.x;
    assign dy    = (tok_in.y >= ent_reg.y) ? tok_in.y - ent_reg.y : ent_reg.y - tok_in.y;
    assign dx_sq = 32'(dx) * 32'(dx);
    assign dy_sq = 32'(dy) * 32'(dy);
    assign d_sq  = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign near  = d_sq < {1'b0, r_sq};

    always_comb
    begin
        used_next = used_reg;
        ent_next  = ent_reg;
        tok_next  = tok_in;
        if (tok_in.vld && tok_in.act == ACT_KEYPOINT && !tok_in.done)
        begin
            if (used_reg && near)
            begin
                if (ent_reg.hits != HITS_MAX)
                    ent_next.hits = ent_reg.hits + 16'd1;
                ent_next.seen = tok_in.t;
                tok_next.done = 1'b1;
            end
            else if (!used_reg)
            begin
                used_next     = 1'b1;
                ent_next.x    = tok_in.x;
                ent_next.y    = tok_in.y;
                ent_next.size = tok_in.size;
                ent_next.hits = 16'd1;
                ent_next.seen = tok_in.t;
                tok_next.done = 1'b1;
            end
        end
        else if (tok_in.vld && tok_in.act == ACT_EOF && used_reg &&
                 (!tok_in.best_vld || ent_reg.hits > tok_in.best.hits))
        begin
            tok_next.best_vld = 1'b1;
            tok_next.best     = ent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            ent_reg  <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            ent_reg  <= ent_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[tb/sv/blob_track_history_table_top_tb.sv]
// ----------------------------------------------------------------------------
// blob_track_history_table_top_tb: self-checking bench for the blob table
// keypoints and end-of-frame transactions with random gaps, favourite reports
// predicted by a behavioural copy of the table and compared field by field
// ----------------------------------------------------------------------------
module blob_track_history_table_top_tb;

    import bth_pkg::*;

    localparam int DEPTH       = 64;
    localparam int SETTLE      = DEPTH + 8;   // quiet cycles before a register write
    localparam int CYCLE_LIMIT = 1000000;

    // kinds of entry in the stimulus queue
    typedef enum logic [1:0] {
        STEP_TRANSACTION,
        STEP_DRAIN,
        STEP_RADIUS
    } step_kind_e;

    typedef struct {
        step_kind_e  kind;
        logic        act;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] size;
        logic [31:0] t;
        logic [15:0] radius;
    } step_t;

    typedef struct {
        logic        valid;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] size;
        logic [15:0] count;
        logic [31:0] seen;
        logic        dropped;
    } fav_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = ACT_KEYPOINT;
    logic [15:0] kp_x = '0;
    logic [15:0] kp_y = '0;
    logic [15:0] kp_size = '0;
    logic [31:0] frame_time = '0;
    logic        done;
    logic        fav_valid;
    logic [15:0] fav_x;
    logic [15:0] fav_y;
    logic [15:0] fav_size;
    logic [15:0] fav_count;
    logic [31:0] fav_last_seen;
    logic        dropped_flag;

    blob_track_history_table_top #(.TABLE_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .kp_x          (kp_x),
        .kp_y          (kp_y),
        .kp_size       (kp_size),
        .frame_time    (frame_time),
        .done          (done),
        .fav_valid     (fav_valid),
        .fav_x         (fav_x),
        .fav_y         (fav_y),
        .fav_size      (fav_size),
        .fav_count     (fav_count),
        .fav_last_seen (fav_last_seen),
        .dropped_flag  (dropped_flag)
    );

    // 12 unit period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // behavioural copy of the table, updated as each transaction is taken
    // ------------------------------------------------------------------
    entry_t      track_tbl [DEPTH];
    int          tracks_used = 0;
    logic        drop_seen = 1'b0;
    logic [15:0] radius_now = 16'd320;

    fav_report_t reports_due[$];
    step_t       steps_pending[$];
    int          mismatches = 0;
    bit          all_queued = 0;

    // first entry strictly inside the radius takes the hit, else append or drop
    function automatic void track_keypoint(logic [15:0] x, logic [15:0] y,
                                           logic [15:0] sz, logic [31:0] t);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned r2;
        r2 = longint'(radius_now) * longint'(radius_now);
        for (int i = 0; i < tracks_used; i++)
        begin
            dx = (x >= track_tbl[i].x) ? x - track_tbl[i].x : track_tbl[i].x - x;
            dy = (y >= track_tbl[i].y) ? y - track_tbl[i].y : track_tbl[i].y - y;
            if (dx * dx + dy * dy < r2)
            begin
                if (track_tbl[i].hits != HITS_MAX)
                    track_tbl[i].hits++;
                track_tbl[i].seen = t;
                return;
            end
        end
        if (tracks_used < DEPTH)
        begin
            track_tbl[tracks_used] = '{x: x, y: y, size: sz, hits: 16'd1, seen: t};
            tracks_used++;
        end
        else
            drop_seen = 1'b1;
    endfunction

    // favourite: first entry with the highest count, zeros when empty
    function automatic fav_report_t favourite_of_table();
        fav_report_t rep;
        int          best;
        rep = '{default: '0};
        rep.dropped = drop_seen;
        best = 0;
        if (tracks_used > 0)
        begin
            for (int i = 1; i < tracks_used; i++)
                if (track_tbl[i].hits > track_tbl[best].hits)
                    best = i;
            rep.valid = 1'b1;
            rep.x     = track_tbl[best].x;
            rep.y     = track_tbl[best].y;
            rep.size  = track_tbl[best].size;
            rep.count = track_tbl[best].hits;
            rep.seen  = track_tbl[best].seen;
        end
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // driver: one transaction at a time, random gap after each acceptance
    // ------------------------------------------------------------------
    int gap_left = 0;
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        logic  start_nxt;
        logic  we_nxt;
        step_t s;
        start_nxt = start;
        we_nxt = 1'b0;
        if (rst_n)
        begin
            quiet_cycles = (busy || start) ? 0 : quiet_cycles + 1;
            if (start && !busy)
            begin
                // transaction taken at this edge
                if (action == ACT_EOF)
                    reports_due.insert(reports_due.size(), favourite_of_table());
                else
                    track_keypoint(kp_x, kp_y, kp_size, frame_time);
                start_nxt = 1'b0;
                gap_left = $urandom_range(0, 9);
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (steps_pending.size() > 0)
                begin
                    s = steps_pending[0];
                    if (s.kind == STEP_TRANSACTION)
                    begin
                        void'(steps_pending.pop_front());
                        action     <= s.act;
                        kp_x       <= s.x;
                        kp_y       <= s.y;
                        kp_size    <= s.size;
                        frame_time <= s.t;
                        start_nxt  = 1'b1;
                    end
                    // drains and register writes only once the block is idle
                    else if (reports_due.size() == 0 && quiet_cycles >= SETTLE)
                    begin
                        void'(steps_pending.pop_front());
                        if (s.kind == STEP_RADIUS)
                        begin
                            we_nxt = 1'b1;
                            cfg_wdata <= s.radius;
                            radius_now = s.radius;
                        end
                    end
                end
            end
        end
        start  <= start_nxt;
        cfg_we <= we_nxt;
    end

    // ------------------------------------------------------------------
    // monitor: done marks a one-cycle result, checked against oldest report
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        fav_report_t want;
        if (rst_n && done)
        begin
            if (reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: fav_valid=%0d x=%h y=%h",
                             fav_valid, fav_x, fav_y);
            end
            else
            begin
                want = reports_due.pop_front();
                if (fav_valid !== want.valid || fav_x !== want.x || fav_y !== want.y ||
                    fav_size !== want.size || fav_count !== want.count ||
                    fav_last_seen !== want.seen || dropped_flag !== want.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp v=%0d x=%h y=%h sz=%h n=%h t=%h d=%0d %s",
                                 want.valid, want.x, want.y, want.size, want.count,
                                 want.seen, want.dropped, "");
                    if (mismatches <= 10)
                        $display("         got v=%0d x=%h y=%h sz=%h n=%h t=%h d=%0d",
                                 fav_valid, fav_x, fav_y, fav_size, fav_count,
                                 fav_last_seen, dropped_flag);
                end
            end
        end
    end

    // watchdog
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void append_step(step_t s);
        steps_pending.insert(steps_pending.size(), s);
    endfunction

    function automatic void queue_obs(logic [15:0] x, logic [15:0] y,
                                      logic [15:0] sz, logic [31:0] t);
        append_step('{kind: STEP_TRANSACTION, act: ACT_KEYPOINT, x: x, y: y,
                      size: sz, t: t, radius: '0});
    endfunction

    function automatic void queue_frame_end();
        append_step('{kind: STEP_TRANSACTION, act: ACT_EOF, x: 16'($urandom),
                      y: 16'($urandom), size: 16'($urandom), t: $urandom, radius: '0});
    endfunction

    function automatic void queue_radius(logic [15:0] r);
        append_step('{kind: STEP_RADIUS, act: ACT_KEYPOINT, x: '0, y: '0,
                      size: '0, t: '0, radius: r});
    endfunction

    logic [15:0] spots_x[$];
    logic [15:0] spots_y[$];
    logic [15:0] phase_radius[8] = '{16'd320, 16'd0, 16'd65535, 16'd1,
                                     16'd320, 16'd4000, 16'd320, 16'd640};

    initial
    begin
        int          k;
        int          pick;
        logic [15:0] jx;
        logic [15:0] jy;

        // directed: empty table, extremes, repeat hit, tie between entries
        queue_frame_end();
        queue_obs(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_obs(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_frame_end();                        // tie, lowest index wins
        queue_obs(16'h0010, 16'h0010, 16'h1234, 32'd77);  // hits entry 0
        queue_frame_end();
        queue_obs(16'hFFF0, 16'hFFF0, 16'h5555, 32'd99);
        queue_obs(16'hFFF0, 16'hFFF0, 16'hAAAA, 32'd100);
        queue_frame_end();
        append_step('{kind: STEP_DRAIN, act: ACT_KEYPOINT, x: '0, y: '0,
                      size: '0, t: '0, radius: '0});
        spots_x = '{16'h0000, 16'hFFFF};
        spots_y = '{16'h0000, 16'hFFFF};

        // random phases, one radius per phase, mostly revisits of known spots
        for (int ph = 0; ph < 8; ph++)
        begin
            queue_radius(ph == 7 ? 16'($urandom) : phase_radius[ph]);
            for (int n = 0; n < 200; n++)
            begin
                k = $urandom_range(0, 99);
                if (k < 20)
                    queue_frame_end();
                else if (k < 32)
                begin
                    jx = 16'($urandom);
                    jy = 16'($urandom);
                    spots_x.insert(spots_x.size(), jx);
                    spots_y.insert(spots_y.size(), jy);
                    queue_obs(jx, jy, 16'($urandom), $urandom);
                end
                else
                begin
                    pick = $urandom_range(0, spots_x.size() - 1);
                    jx = spots_x[pick] + 16'($urandom_range(0, 400)) - 16'd200;
                    jy = spots_y[pick] + 16'($urandom_range(0, 400)) - 16'd200;
                    queue_obs(jx, jy, 16'($urandom), $urandom);
                end
                // occasional full pause until all reports are back
                if ($urandom_range(0, 99) == 0)
                    append_step('{kind: STEP_DRAIN, act: ACT_KEYPOINT,
                                  x: '0, y: '0, size: '0, t: '0, radius: '0});
            end
        end
        queue_frame_end();

        // reset once at the start
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (steps_pending.size() == 0 && !start);
        wait (reports_due.size() == 0);
        repeat (SETTLE * 2) @(posedge clk);

        if (mismatches == 0 && reports_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
